### rtl/core/blcd_pkg.sv
package blcd_pkg;

    localparam int PIX_W     = 8;
    localparam int MAX_WIDTH = 4096;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int LINE_ROWS = 4;
    localparam int POS_W     = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_ADDR_W = 3;

    localparam logic [POS_W-1:0] MIN_DIM    = 13'd4;
    localparam logic [POS_W-1:0] MAX_W_DIM  = 13'd4096;
    localparam logic [POS_W-1:0] MAX_H_DIM  = 13'd4096;

    // input kind carried on s_tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN_GAIN   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RED_GAIN     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUE_GAIN    = 3'd4;

    // one column of the window, rows r-2 .. r+2
    typedef logic [4:0][PIX_W-1:0] colv_t;
    // window, columns c-2 .. c+2
    typedef colv_t [4:0] win_t;

    typedef struct packed {
        logic odd_r;
        logic odd_c;
        logic row_end;
        logic frame_end;
    } flags_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             row_end;
        logic             frame_end;
    } res_t;

endpackage

### rtl/core/blcd_ram.sv
module blcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/blcd_filter.sv
module blcd_filter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          enable,
    input  logic                          in_valid,
    input  blcd_pkg::win_t                win,
    input  blcd_pkg::flags_t              flags,
    input  logic [blcd_pkg::PIX_W-1:0]    green_gain,
    input  logic [blcd_pkg::PIX_W-1:0]    red_gain,
    input  logic [blcd_pkg::PIX_W-1:0]    blue_gain,
    output logic                          out_valid,
    output blcd_pkg::res_t                out_res
);

    typedef enum logic [1:0] {
        SITE_RED  = 2'd0,
        SITE_GR   = 2'd1,
        SITE_GB   = 2'd2,
        SITE_BLUE = 2'd3
    } site_t;

    logic [7:0]         p0;
    logic [8:0]         hz, vt;
    logic [9:0]         hv, dg, ax;
    logic signed [10:0] lap;
    site_t              site;
    logic [7:0]         gain_a, gain_b;
    logic [17:0]        base_a, base_b;
    logic signed [19:0] prod_a, prod_b;

    logic               valid_reg;
    site_t              site_reg;
    logic [7:0]         p0_reg;
    logic [17:0]        base_a_reg, base_b_reg;
    logic signed [19:0] prod_a_reg, prod_b_reg;
    logic               row_end_reg, frame_end_reg;
    logic [7:0]         val_a, val_b;

    function automatic logic [7:0] finish(input logic [17:0] base,
                                          input logic signed [19:0] prod);
        logic signed [21:0] t;
        t = $signed({4'b0, base}) + $signed({{2{prod[19]}}, prod}) + 22'sd512;
        if (t[21]) begin
            return 8'd0;
        end else if (|t[20:18]) begin
            return 8'hFF;
        end else begin
            return t[17:10];
        end
    endfunction

    always_comb begin
        p0  = win[2][2];
        hz  = {1'b0, win[1][2]} + {1'b0, win[3][2]};
        vt  = {1'b0, win[2][1]} + {1'b0, win[2][3]};
        hv  = {1'b0, hz} + {1'b0, vt};
        dg  = {2'b0, win[1][1]} + {2'b0, win[3][1]} + {2'b0, win[1][3]} + {2'b0, win[3][3]};
        ax  = {2'b0, win[0][2]} + {2'b0, win[4][2]} + {2'b0, win[2][0]} + {2'b0, win[2][4]};
        lap = $signed({1'b0, p0, 2'b00}) - $signed({1'b0, ax});
        site = site_t'({flags.odd_r, flags.odd_c});
        case ({flags.odd_r, flags.odd_c})
            2'b00:   site = SITE_RED;
            2'b01:   site = SITE_GR;
            2'b10:   site = SITE_GB;
            default: site = SITE_BLUE;
        endcase
        // channel A is green at red/blue sites, red at green sites; B is the other one
        case (site)
            SITE_RED: begin
                gain_a = green_gain;
                gain_b = blue_gain;
                base_a = {hv, 8'b0};
                base_b = {dg, 8'b0};
            end
            SITE_BLUE: begin
                gain_a = green_gain;
                gain_b = red_gain;
                base_a = {hv, 8'b0};
                base_b = {dg, 8'b0};
            end
            SITE_GR: begin
                gain_a = red_gain;
                gain_b = blue_gain;
                base_a = {hz, 9'b0};
                base_b = {vt, 9'b0};
            end
            default: begin
                gain_a = red_gain;
                gain_b = blue_gain;
                base_a = {vt, 9'b0};
                base_b = {hz, 9'b0};
            end
        endcase
        prod_a = $signed({1'b0, gain_a}) * lap;
        prod_b = $signed({1'b0, gain_b}) * lap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (enable) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            site_reg      <= site;
            p0_reg        <= p0;
            base_a_reg    <= base_a;
            base_b_reg    <= base_b;
            prod_a_reg    <= prod_a;
            prod_b_reg    <= prod_b;
            row_end_reg   <= flags.row_end;
            frame_end_reg <= flags.frame_end;
        end
    end

    always_comb begin
        val_a = finish(base_a_reg, prod_a_reg);
        val_b = finish(base_b_reg, prod_b_reg);
        out_valid         = valid_reg;
        out_res.row_end   = row_end_reg;
        out_res.frame_end = frame_end_reg;
        case (site_reg)
            SITE_RED: begin
                out_res.red   = p0_reg;
                out_res.green = val_a;
                out_res.blue  = val_b;
            end
            SITE_BLUE: begin
                out_res.red   = val_b;
                out_res.green = val_a;
                out_res.blue  = p0_reg;
            end
            default: begin
                out_res.red   = val_a;
                out_res.green = p0_reg;
                out_res.blue  = val_b;
            end
        endcase
    end

endmodule

### rtl/core/bayer_laplacian_corrected_demosaic.sv
// Channel   Dir  Word                                   Side band
// s_        in   tdata[7:0] raw_pixel                   tuser: op (0 pixel, 1 flush)
// m_        out  tdata[7:0] red, [15:8] green, [23:16]  tuser[0] row_end, [1] frame_end,
//                blue                                   tlast: last_in_run
// cfg_      in   wdata, addr 0..4 (width, height, gains) none
//
// One word is accepted per cycle while the skid register is empty.
// The rate is set by the four line RAMs: one read of every row and one write per pixel word.
// Results lag the pixels by two rows and two pixels; flush words drain the last ones.
// Reset clears counters and handshake state; the line RAMs need no clearing.
// A skid register behind the output keeps s_tready high while one result waits.
module bayer_laplacian_corrected_demosaic (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] raw_pixel
    input  logic                                s_tuser,   // [0] op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // red, green, blue
    output logic [1:0]                          m_tuser,   // row_end, frame_end
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [blcd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [blcd_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int PW = blcd_pkg::POS_W;
    localparam int NR = blcd_pkg::LINE_ROWS;

    typedef struct packed {
        logic       valid;
        logic       emit;
        logic [7:0] pixel;
        logic [1:0] slot;
        logic       col_first;
        logic       col_second;
        logic       col_third;
        logic       row_top0;
        logic       row_top1;
        logic       row_bot0;
        logic       row_bot1;
        blcd_pkg::flags_t flags;
    } meta1_t;

    logic [PW-1:0] frame_width_reg, frame_height_reg;
    logic [7:0]    green_gain_reg, red_gain_reg, blue_gain_reg;

    logic [PW-1:0] cur_w_reg, cur_h_reg, in_row_reg, in_col_reg, out_row_reg, out_col_reg;
    logic [PW-1:0] cur_w_next, cur_h_next, in_row_next, in_col_next, out_row_next, out_col_next;
    logic          busy_reg, all_in_reg, busy_next, all_in_next;

    logic          enable, accept, pix, draining, start, act, emit_now;
    logic          col_wrap, out_last_col, out_last;
    logic [PW-1:0] eff_w, eff_h, eff_row, eff_col;

    logic [7:0]          rd_data [NR];
    meta1_t              m1_reg;
    blcd_pkg::colv_t     raw, vec;
    blcd_pkg::colv_t     pre0_reg, pre1_reg;
    blcd_pkg::win_t      win_reg, win_next;
    logic                v2_reg;
    blcd_pkg::flags_t    f2_reg;

    logic                res_valid;
    blcd_pkg::res_t      res;
    logic                m_valid_reg, skid_valid_reg;
    blcd_pkg::res_t      m_res_reg, skid_res_reg;

    function automatic logic [PW-1:0] clamp_dim(input logic [PW-1:0] v,
                                                input logic [PW-1:0] hi);
        if (v < blcd_pkg::MIN_DIM) begin
            return blcd_pkg::MIN_DIM;
        end else if (v > hi) begin
            return hi;
        end else begin
            return v;
        end
    endfunction

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 13'd4096;
            frame_height_reg <= 13'd3072;
            green_gain_reg   <= 8'd128;
            red_gain_reg     <= 8'd160;
            blue_gain_reg    <= 8'd192;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                blcd_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                blcd_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                blcd_pkg::REG_GREEN_GAIN:   green_gain_reg   <= cfg_wdata[7:0];
                blcd_pkg::REG_RED_GAIN:     red_gain_reg     <= cfg_wdata[7:0];
                blcd_pkg::REG_BLUE_GAIN:    blue_gain_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // input position and frame control
    assign enable   = !skid_valid_reg;
    assign s_tready = enable;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        pix      = s_tuser == blcd_pkg::OP_PIXEL;
        draining = busy_reg && all_in_reg;
        start    = pix && (!busy_reg || all_in_reg);
        act      = pix || draining;
        eff_w    = start ? clamp_dim(frame_width_reg, blcd_pkg::MAX_W_DIM) : cur_w_reg;
        eff_h    = start ? clamp_dim(frame_height_reg, blcd_pkg::MAX_H_DIM) : cur_h_reg;
        eff_row  = start ? '0 : in_row_reg;
        eff_col  = start ? '0 : in_col_reg;
        emit_now = pix ? ((eff_row > 13'd2) || (eff_row == 13'd2 && eff_col >= 13'd2))
                       : draining;
        col_wrap     = eff_col == eff_w - 13'd1;
        out_last_col = out_col_reg == eff_w - 13'd1;
        out_last     = out_last_col && (out_row_reg == eff_h - 13'd1);

        cur_w_next   = cur_w_reg;
        cur_h_next   = cur_h_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        busy_next    = busy_reg;
        all_in_next  = all_in_reg;
        if (accept && act) begin
            cur_w_next = eff_w;
            cur_h_next = eff_h;
            if (start) begin
                busy_next    = 1'b1;
                all_in_next  = 1'b0;
                out_row_next = '0;
                out_col_next = '0;
            end
            // past the last row the position keeps running as virtual rows for draining
            in_col_next = col_wrap ? '0 : eff_col + 13'd1;
            in_row_next = col_wrap ? eff_row + 13'd1 : eff_row;
            if (pix && col_wrap && eff_row == eff_h - 13'd1) begin
                all_in_next = 1'b1;
            end
            if (emit_now) begin
                out_col_next = out_last_col ? '0 : out_col_reg + 13'd1;
                out_row_next = out_last_col ? out_row_reg + 13'd1 : out_row_reg;
                if (out_last) begin
                    out_row_next = '0;
                    busy_next    = 1'b0;
                    all_in_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_w_reg   <= blcd_pkg::MIN_DIM;
            cur_h_reg   <= blcd_pkg::MIN_DIM;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            busy_reg    <= 1'b0;
            all_in_reg  <= 1'b0;
        end else begin
            cur_w_reg   <= cur_w_next;
            cur_h_reg   <= cur_h_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            busy_reg    <= busy_next;
            all_in_reg  <= all_in_next;
        end
    end

    // line RAMs, one per row modulo four, all read at the incoming column
    for (genvar g = 0; g < NR; g++) begin : g_line
        blcd_ram #(
            .WIDTH (blcd_pkg::PIX_W),
            .DEPTH (blcd_pkg::MAX_WIDTH)
        ) u_line (
            .aclk    (aclk),
            .wr_en   (accept && pix && (eff_row[1:0] == 2'(g))),
            .wr_addr (eff_col[blcd_pkg::COL_BITS-1:0]),
            .wr_data (s_tdata),
            .rd_en   (accept),
            .rd_addr (eff_col[blcd_pkg::COL_BITS-1:0]),
            .rd_data (rd_data[g])
        );
    end

    // stage 1: word metadata alongside the RAM read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_reg.valid <= 1'b0;
        end else if (enable) begin
            m1_reg.valid <= accept && act;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            m1_reg.emit            <= emit_now;
            m1_reg.pixel           <= s_tdata;
            m1_reg.slot            <= eff_row[1:0];
            m1_reg.col_first       <= eff_col == 13'd0;
            m1_reg.col_second      <= eff_col == 13'd1;
            m1_reg.col_third       <= eff_col == 13'd2;
            m1_reg.row_top0        <= eff_row == 13'd2;
            m1_reg.row_top1        <= eff_row == 13'd3;
            m1_reg.row_bot0        <= eff_row == eff_h;
            m1_reg.row_bot1        <= eff_row == eff_h + 13'd1;
            m1_reg.flags.odd_r     <= out_row_reg[0];
            m1_reg.flags.odd_c     <= out_col_reg[0];
            m1_reg.flags.row_end   <= out_last_col;
            m1_reg.flags.frame_end <= out_last;
        end
    end

    // column vector with border rows reflected
    always_comb begin
        raw[0] = rd_data[m1_reg.slot];
        raw[1] = rd_data[m1_reg.slot + 2'd1];
        raw[2] = rd_data[m1_reg.slot + 2'd2];
        raw[3] = rd_data[m1_reg.slot + 2'd3];
        raw[4] = m1_reg.pixel;
        vec    = raw;
        if (m1_reg.row_top0) begin
            vec[0] = raw[4];
            vec[1] = raw[3];
        end
        if (m1_reg.row_top1) begin
            vec[0] = raw[2];
        end
        if (m1_reg.row_bot0) begin
            vec[4] = raw[2];
        end
        if (m1_reg.row_bot1) begin
            vec[3] = raw[1];
            vec[4] = raw[0];
        end

        // shift one column; at the right edge feed a reflected column, at the third column rebuild the left edge
        win_next[3:0] = win_reg[4:1];
        win_next[4]   = vec;
        if (m1_reg.col_first) begin
            win_next[4] = win_reg[3];
        end else if (m1_reg.col_second) begin
            win_next[4] = win_reg[1];
        end else if (m1_reg.col_third) begin
            win_next[0] = vec;
            win_next[1] = pre1_reg;
            win_next[2] = pre0_reg;
            win_next[3] = pre1_reg;
            win_next[4] = vec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (enable) begin
            v2_reg <= m1_reg.valid && m1_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            f2_reg <= m1_reg.flags;
            if (m1_reg.valid) begin
                win_reg <= win_next;
                // hold the first two columns of the next row during the edge pixels
                if (m1_reg.col_first) begin
                    pre0_reg <= vec;
                end
                if (m1_reg.col_second) begin
                    pre1_reg <= vec;
                end
            end
        end
    end

    // stages 2 and 3: interpolation and correction
    blcd_filter u_filter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .enable     (enable),
        .in_valid   (v2_reg),
        .win        (win_reg),
        .flags      (f2_reg),
        .green_gain (green_gain_reg),
        .red_gain   (red_gain_reg),
        .blue_gain  (blue_gain_reg),
        .out_valid  (res_valid),
        .out_res    (res)
    );

    // output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg    <= skid_valid_reg || (enable && res_valid);
            skid_valid_reg <= 1'b0;
        end else if (enable && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            m_res_reg <= skid_valid_reg ? skid_res_reg : res;
        end else if (enable && res_valid) begin
            skid_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.blue, m_res_reg.green, m_res_reg.red};
    assign m_tuser  = {m_res_reg.frame_end, m_res_reg.row_end};
    assign m_tlast  = 1'b1;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a word while output is empty");

    a_drain_needs_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        all_in_reg |-> busy_reg)
        else $error("frame complete flag set outside a frame");

    a_frame_end_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.frame_end |-> m_res_reg.row_end)
        else $error("frame end without row end");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !all_in_reg |-> in_row_reg < cur_h_reg)
        else $error("input row beyond frame height while receiving");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 12;
    localparam int LONG_HOLD   = 300;
    localparam int ITEM_TARGET = 260;
    localparam logic [blcd_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       frame_end;
    } rgb_word_t;

    class demosaic_scoreboard;
        int unsigned width_reg, height_reg, g_gain, r_gain, b_gain;
        int          fr_w, fr_h, in_row, in_col, out_row, out_col;
        bit          busy, all_in;
        logic [7:0]  rows [8][blcd_pkg::MAX_WIDTH];
        rgb_word_t   rgb_expected [$];
        int          errors;

        function new();
            width_reg  = 4096;
            height_reg = 3072;
            g_gain = 128;
            r_gain = 160;
            b_gain = 192;
            fr_w = 4;
            fr_h = 4;
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            busy = 0; all_in = 0; errors = 0;
        endfunction

        function void report(string what);
            $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endfunction

        function int pending();
            return rgb_expected.size();
        endfunction

        function void write_reg(logic [blcd_pkg::CFG_ADDR_W-1:0] idx,
                                logic [blcd_pkg::CFG_W-1:0] val);
            case (idx)
                blcd_pkg::REG_FRAME_WIDTH:  width_reg  = val;
                blcd_pkg::REG_FRAME_HEIGHT: height_reg = val;
                blcd_pkg::REG_GREEN_GAIN:   g_gain = val[7:0];
                blcd_pkg::REG_RED_GAIN:     r_gain = val[7:0];
                blcd_pkg::REG_BLUE_GAIN:    b_gain = val[7:0];
                default: ;
            endcase
        endfunction

        function int reflect(int i, int n);
            if (i < 0) i = -i;
            if (i >= n) i = 2 * (n - 1) - i;
            return i;
        endfunction

        function longint tap(int dr, int dc);
            int r, c;
            r = reflect(out_row + dr, fr_h);
            c = reflect(out_col + dc, fr_w);
            return rows[r % 8][c];
        endfunction

        function logic [7:0] round_sat(longint num);
            longint t;
            t = num + 512;
            if (t < 0) return 8'd0;
            t = t >>> 10;
            return (t > 255) ? 8'd255 : t[7:0];
        endfunction

        function void emit_pixel();
            longint p0, hz, vt, dg, lap;
            rgb_word_t w;
            p0  = tap(0, 0);
            hz  = tap(0, -1) + tap(0, 1);
            vt  = tap(-1, 0) + tap(1, 0);
            dg  = tap(-1, -1) + tap(-1, 1) + tap(1, -1) + tap(1, 1);
            lap = 4 * p0 - (tap(-2, 0) + tap(2, 0) + tap(0, -2) + tap(0, 2));
            if (out_row % 2 == 0 && out_col % 2 == 0) begin
                w.red   = p0[7:0];
                w.green = round_sat(256 * (hz + vt) + g_gain * lap);
                w.blue  = round_sat(256 * dg + b_gain * lap);
            end else if (out_row % 2 == 1 && out_col % 2 == 1) begin
                w.blue  = p0[7:0];
                w.green = round_sat(256 * (hz + vt) + g_gain * lap);
                w.red   = round_sat(256 * dg + r_gain * lap);
            end else if (out_row % 2 == 0) begin
                w.green = p0[7:0];
                w.red   = round_sat(512 * hz + r_gain * lap);
                w.blue  = round_sat(512 * vt + b_gain * lap);
            end else begin
                w.green = p0[7:0];
                w.red   = round_sat(512 * vt + r_gain * lap);
                w.blue  = round_sat(512 * hz + b_gain * lap);
            end
            w.row_end   = (out_col == fr_w - 1);
            w.frame_end = (out_col == fr_w - 1) && (out_row == fr_h - 1);
            rgb_expected.push_back(w);
            out_col++;
            if (out_col >= fr_w) begin
                out_col = 0;
                out_row++;
                if (out_row >= fr_h) begin
                    out_row = 0;
                    busy = 0;
                    all_in = 0;
                end
            end
        endfunction

        function void note_word(logic op, logic [7:0] pix);
            if (op == blcd_pkg::OP_FLUSH) begin
                if (busy && all_in) emit_pixel();
                return;
            end
            // a pixel while idle or draining opens a new frame
            if (!busy || all_in) begin
                fr_w = (width_reg < 4) ? 4 :
                       (width_reg > blcd_pkg::MAX_WIDTH ? blcd_pkg::MAX_WIDTH : width_reg);
                fr_h = (height_reg < 4) ? 4 : (height_reg > 4096 ? 4096 : height_reg);
                in_row = 0; in_col = 0; out_row = 0; out_col = 0;
                busy = 1;
                all_in = 0;
            end
            rows[in_row % 8][in_col] = pix;
            if (in_row * fr_w + in_col >= 2 * fr_w + 2) emit_pixel();
            in_col++;
            if (in_col >= fr_w) begin
                in_col = 0;
                in_row++;
                if (in_row >= fr_h) begin
                    in_row = 0;
                    all_in = 1;
                end
            end
        endfunction

        function void check_result(logic [23:0] data, logic [1:0] user, logic last);
            rgb_word_t w;
            if (rgb_expected.size() == 0) begin
                report($sformatf("unexpected word %h/%b", data, user));
                return;
            end
            w = rgb_expected.pop_front();
            if (data[7:0] !== w.red)
                report($sformatf("red %h, want %h", data[7:0], w.red));
            if (data[15:8] !== w.green)
                report($sformatf("green %h, want %h", data[15:8], w.green));
            if (data[23:16] !== w.blue)
                report($sformatf("blue %h, want %h", data[23:16], w.blue));
            if (user[0] !== w.row_end)
                report($sformatf("row_end %b, want %b", user[0], w.row_end));
            if (user[1] !== w.frame_end)
                report($sformatf("frame_end %b, want %b", user[1], w.frame_end));
            if (last !== 1'b1)
                report("last_in_run low");
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [23:0]                     m_tdata;
    logic [1:0]                      m_tuser;
    logic                            m_tlast;
    logic                            cfg_wr_en;
    logic [blcd_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [blcd_pkg::CFG_W-1:0]      cfg_wdata;

    demosaic_scoreboard sb = new();
    int  cycles;
    int  items;
    bit  quiet;
    bit  hold_req;

    bayer_laplacian_corrected_demosaic DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata);
        if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result side: random stalls, long holds on request, none near the end
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 0;
            end else if (quiet) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                if ($urandom_range(0, 1)) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge aclk);
                end
            end
        end
    end

    task automatic send_word(logic op, logic [7:0] pix);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        items++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        // let the monitor note the last accepted word first
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_regs(int w, int h, int gg, int rg, int bg);
        logic [blcd_pkg::CFG_ADDR_W-1:0] idx [5];
        int vals [5];
        idx  = '{blcd_pkg::REG_FRAME_WIDTH, blcd_pkg::REG_FRAME_HEIGHT,
                 blcd_pkg::REG_GREEN_GAIN, blcd_pkg::REG_RED_GAIN, blcd_pkg::REG_BLUE_GAIN};
        vals = '{w, h, gg, rg, bg};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= blcd_pkg::CFG_W'(vals[i]);
            @(posedge aclk);
            sb.write_reg(idx[i], blcd_pkg::CFG_W'(vals[i]));
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // pattern 0 random, 1 checkerboard of extremes, 2 saturated
    task automatic send_frame(int w, int h, int pattern, int drain);
        for (int i = 0; i < w * h; i++) begin
            case (pattern)
                1:       send_word(blcd_pkg::OP_PIXEL, ((i / w + i) % 2) ? 8'hFF : 8'h00);
                2:       send_word(blcd_pkg::OP_PIXEL, 8'hFF);
                default: send_word(blcd_pkg::OP_PIXEL, 8'($urandom_range(0, 255)));
            endcase
        end
        for (int i = 0; i < drain; i++)
            send_word(blcd_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int w, h, drain;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= blcd_pkg::OP_PIXEL;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        cycles = 0;
        items = 0;
        quiet = 0;
        hold_req = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // out-of-range register index and oversized geometry, then clamp low
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_UNUSED;
        cfg_wdata <= 13'h1FFF;
        @(posedge aclk);
        sb.write_reg(REG_UNUSED, 13'h1FFF);
        set_regs(8191, 8191, 255, 255, 255);
        set_regs(0, 0, 0, 0, 0);
        send_word(blcd_pkg::OP_FLUSH, 8'hFF);
        send_frame(4, 1, 1, 0);
        send_word(blcd_pkg::OP_FLUSH, 8'h00);
        send_frame(4, 3, 1, 10);
        wait_drained();
        set_regs(4, 4, 255, 255, 255);
        send_frame(4, 4, 1, 10);
        wait_drained();

        while (items < ITEM_TARGET) begin
            if (items > ITEM_TARGET - 50) quiet = 1;
            w = $urandom_range(4, 12);
            h = $urandom_range(4, 7);
            if ($urandom_range(0, 4) == 0)
                set_regs(w, h, 255 * $urandom_range(0, 1), 255 * $urandom_range(0, 1),
                         255 * $urandom_range(0, 1));
            else
                set_regs(w, h, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
            if (items < 80 && !hold_req) hold_req = 1;
            // sometimes cut the drain short and restart with the same geometry
            drain = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2 * w + 1) : 2 * w + 2;
            send_frame(w, h, ($urandom_range(0, 7) == 0) ? 2 : 0, drain);
            if (drain < 2 * w + 2) send_frame(w, h, 0, 2 * w + 2);
            if (!quiet && $urandom_range(0, 3) == 0)
                send_word(blcd_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
            wait_drained();
        end
        quiet = 1;
        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
